/* hw/rtl/ftc_pkg.sv */
// ----------------------------------------------------------------------------
// ftc_pkg: shared definitions for the float tolerance compare block
// Register indexes, binary64 constants, pipeline sideband types and the
// small helper functions used by the arithmetic stages.
// ----------------------------------------------------------------------------
package ftc_pkg;

  localparam logic [1:0] CFG_REL_TOL = 2'd0;
  localparam logic [1:0] CFG_ABS_TOL = 2'd1;
  localparam logic [1:0] CFG_NAN_EQ  = 2'd2;

  localparam logic [63:0] F64_QNAN = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX  = 11'h7FF;

  // Per-item flags that travel beside the arithmetic pipeline.
  typedef struct packed {
    logic func;
    logic lnan;
    logic rnan;
  } ftc_side_t;

  // Special-case flags of the multiplier.
  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sign;
  } ftc_mflag_t;

  function automatic logic f64_is_nan(input logic [63:0] x);
    return (x[62:52] == EXP_MAX) && (x[51:0] != 52'd0);
  endfunction

  // IEEE less-or-equal on two binary64 values; unordered gives false.
  function automatic logic f64_le(input logic [63:0] x, input logic [63:0] y);
    logic res;
    if (f64_is_nan(x) || f64_is_nan(y)) begin
      res = 1'b0;
    end else if ((x[62:0] == 63'd0) && (y[62:0] == 63'd0)) begin
      res = 1'b1;
    end else if (x[63] != y[63]) begin
      res = x[63];
    end else if (!x[63]) begin
      res = x[62:0] <= y[62:0];
    end else begin
      res = x[62:0] >= y[62:0];
    end
    return res;
  endfunction

  // Leading zero count of a 106-bit word; an all-zero word gives 106.
  function automatic logic [6:0] lzc106(input logic [105:0] v);
    logic [6:0] n;
    n = 7'd106;
    for (int i = 0; i < 106; i++) begin
      if (v[i]) begin
        n = 7'(105 - i);
      end
    end
    return n;
  endfunction

endpackage

/* hw/rtl/ftc_req_if.sv */
// ----------------------------------------------------------------------------
// ftc_req_if: request channel of the float tolerance compare block
// Valid/ready handshake carrying one operand pair per transfer.
// ----------------------------------------------------------------------------
interface ftc_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] left_real;
  logic [63:0] left_imag;
  logic [63:0] right_real;
  logic [63:0] right_imag;

  modport source (output valid, func, left_real, left_imag, right_real, right_imag,
                  input ready);
  modport sink   (input valid, func, left_real, left_imag, right_real, right_imag,
                  output ready);
endinterface

/* hw/rtl/ftc_rsp_if.sv */
// ----------------------------------------------------------------------------
// ftc_rsp_if: response channel of the float tolerance compare block
// Valid/ready handshake carrying one compare result per transfer.
// ----------------------------------------------------------------------------
interface ftc_rsp_if;
  logic valid;
  logic ready;
  logic is_close;

  modport source (output valid, is_close, input ready);
  modport sink   (input valid, is_close, output ready);
endinterface

/* hw/rtl/ftc_sub.sv */
// ----------------------------------------------------------------------------
// ftc_sub: pipelined binary64 absolute difference
// Five register stages: unpack/swap, align, add, normalize, round. The
// output is |a - b| rounded to nearest even.
// ----------------------------------------------------------------------------
module ftc_sub import ftc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] d
);

  // Stage 1 registers
  logic [52:0] s1_mb, s1_ms;
  logic [10:0] s1_eb, s1_diff;
  logic        s1_sub, s1_nan, s1_inf;
  // Stage 2 registers
  logic [55:0] s2_big, s2_sml;
  logic [10:0] s2_eb;
  logic        s2_sub, s2_nan, s2_inf;
  // Stage 3 registers
  logic [56:0] s3_sum;
  logic [10:0] s3_eb;
  logic        s3_nan, s3_inf;
  // Stage 4 registers
  logic [55:0] s4_n;
  logic [11:0] s4_e;
  logic        s4_nan, s4_inf;

  logic [62:0]  ua, ub, ubig, usml;
  logic [10:0]  eb_raw, es_raw, eb1, es1;
  logic [5:0]   dsat;
  logic [111:0] t;
  logic [55:0]  aligned;
  logic [6:0]   lz, lim, sh;
  logic [55:0]  n4;
  logic [11:0]  e4;
  logic [53:0]  m2;
  logic [52:0]  mant_f;
  logic [11:0]  e_f;
  logic         up;
  logic [63:0]  d_next;

  always_comb begin
    ua     = a[62:0];
    ub     = b[62:0];
    ubig   = (ua >= ub) ? ua : ub;
    usml   = (ua >= ub) ? ub : ua;
    eb_raw = ubig[62:52];
    es_raw = usml[62:52];
    eb1    = (eb_raw == 11'd0) ? 11'd1 : eb_raw;
    es1    = (es_raw == 11'd0) ? 11'd1 : es_raw;
  end

  // Alignment: bits shifted past the guard positions fold into a sticky bit.
  always_comb begin
    dsat    = (s1_diff > 11'd57) ? 6'd57 : s1_diff[5:0];
    t       = {s1_ms, 3'b000, 56'd0} >> dsat;
    aligned = {t[111:57], t[56] | (|t[55:0])};
  end

  // Normalize; left shifts stop at the minimum exponent (subnormal result).
  always_comb begin
    lz  = lzc106({s3_sum[55:0], 50'd0});
    lim = (s3_eb - 11'd1 > 11'd127) ? 7'd127 : 7'(s3_eb - 11'd1);
    sh  = (lz > lim) ? lim : lz;
    if (s3_sum[56]) begin
      n4 = {s3_sum[56:2], s3_sum[1] | s3_sum[0]};
      e4 = {1'b0, s3_eb} + 12'd1;
    end else begin
      n4 = s3_sum[55:0] << sh;
      e4 = {1'b0, s3_eb} - 12'(sh);
    end
  end

  always_comb begin
    up = s4_n[2] & (s4_n[1] | s4_n[0] | s4_n[3]);
    m2 = {1'b0, s4_n[55:3]} + 54'(up);
    if (m2[53]) begin
      mant_f = m2[53:1];
      e_f    = s4_e + 12'd1;
    end else begin
      mant_f = m2[52:0];
      e_f    = s4_e;
    end
    if (s4_nan) begin
      d_next = F64_QNAN;
    end else if (s4_inf || e_f >= 12'd2047) begin
      d_next = {1'b0, EXP_MAX, 52'd0};
    end else begin
      d_next = {1'b0, mant_f[52] ? e_f[10:0] : 11'd0, mant_f[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mb   <= {eb_raw != 11'd0, ubig[51:0]};
      s1_ms   <= {es_raw != 11'd0, usml[51:0]};
      s1_eb   <= eb1;
      s1_diff <= eb1 - es1;
      s1_sub  <= a[63] == b[63];
      s1_inf  <= eb_raw == EXP_MAX;
      s1_nan  <= (eb_raw == EXP_MAX) && (es_raw == EXP_MAX) && (a[63] == b[63]);

      s2_big  <= {s1_mb, 3'b000};
      s2_sml  <= aligned;
      s2_eb   <= s1_eb;
      s2_sub  <= s1_sub;
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;

      s3_sum  <= s2_sub ? ({1'b0, s2_big} - {1'b0, s2_sml})
                        : ({1'b0, s2_big} + {1'b0, s2_sml});
      s3_eb   <= s2_eb;
      s3_nan  <= s2_nan;
      s3_inf  <= s2_inf;

      s4_n    <= n4;
      s4_e    <= e4;
      s4_nan  <= s3_nan;
      s4_inf  <= s3_inf;

      d       <= d_next;
    end
  end

endmodule

/* hw/rtl/ftc_mul.sv */
// ----------------------------------------------------------------------------
// ftc_mul: pipelined binary64 product of a tolerance and a larger magnitude
// Computes rt * max(|a|, |b|) rounded to nearest even in five register
// stages: unpack, partial products, sum, normalize, denormalize and round.
// ----------------------------------------------------------------------------
module ftc_mul import ftc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rt,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [52:0]  m1_ma, m1_mb;
  logic [11:0]  m1_es;
  ftc_mflag_t   m1_f;
  logic [51:0]  m2_hh;
  logic [52:0]  m2_hl, m2_lh;
  logic [53:0]  m2_ll;
  logic [11:0]  m2_es;
  ftc_mflag_t   m2_f;
  logic [105:0] m3_p;
  logic [11:0]  m3_es;
  ftc_mflag_t   m3_f;
  logic [105:0] m4_pn;
  logic [13:0]  m4_e;
  ftc_mflag_t   m4_f;

  logic [62:0]  umx;
  logic [10:0]  er_raw, em_raw;
  logic         r_zero, m_zero, r_inf, m_inf, r_nan;
  ftc_mflag_t   f1;
  logic [6:0]   lz;
  logic [13:0]  shamt, e_b;
  logic [6:0]   sh;
  logic [105:0] r;
  logic         lost, up;
  logic [53:0]  m2;
  logic [52:0]  mant_f;
  logic [13:0]  e_f;
  logic [63:0]  p_next;

  always_comb begin
    umx    = (a[62:0] >= b[62:0]) ? a[62:0] : b[62:0];
    er_raw = rt[62:52];
    em_raw = umx[62:52];
    r_zero = rt[62:0] == 63'd0;
    m_zero = umx == 63'd0;
    r_inf  = er_raw == EXP_MAX;
    m_inf  = em_raw == EXP_MAX;
    r_nan  = f64_is_nan(rt);
    f1.nan  = r_nan || (r_inf && m_zero) || (r_zero && m_inf);
    f1.inf  = r_inf || m_inf;
    f1.zero = r_zero || m_zero;
    f1.sign = rt[63];
  end

  // The leading one moves to the top bit; the exponent follows it.
  always_comb begin
    lz = lzc106(m3_p);
  end

  // Results below the normal range shift right into the subnormal format.
  always_comb begin
    if ($signed(m4_e) < 14'sd1) begin
      shamt = 14'd1 - m4_e;
      e_b   = 14'd1;
    end else begin
      shamt = 14'd0;
      e_b   = m4_e;
    end
    sh   = (shamt > 14'd127) ? 7'd127 : shamt[6:0];
    r    = m4_pn >> sh;
    lost = |(m4_pn & ~({106{1'b1}} << sh));
    up   = r[52] & ((|r[51:0]) | lost | r[53]);
    m2   = {1'b0, r[105:53]} + 54'(up);
    if (m2[53]) begin
      mant_f = m2[53:1];
      e_f    = e_b + 14'd1;
    end else begin
      mant_f = m2[52:0];
      e_f    = e_b;
    end
    if (m4_f.nan) begin
      p_next = F64_QNAN;
    end else if (m4_f.inf || $signed(e_f) >= 14'sd2047) begin
      p_next = {m4_f.sign, EXP_MAX, 52'd0};
    end else if (m4_f.zero) begin
      p_next = {m4_f.sign, 63'd0};
    end else begin
      p_next = {m4_f.sign, mant_f[52] ? e_f[10:0] : 11'd0, mant_f[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ma <= {er_raw != 11'd0, rt[51:0]};
      m1_mb <= {em_raw != 11'd0, umx[51:0]};
      m1_es <= 12'((er_raw == 11'd0) ? 11'd1 : er_raw)
             + 12'((em_raw == 11'd0) ? 11'd1 : em_raw);
      m1_f  <= f1;

      m2_hh <= m1_ma[52:27] * m1_mb[52:27];
      m2_hl <= m1_ma[52:27] * m1_mb[26:0];
      m2_lh <= m1_ma[26:0] * m1_mb[52:27];
      m2_ll <= m1_ma[26:0] * m1_mb[26:0];
      m2_es <= m1_es;
      m2_f  <= m1_f;

      m3_p  <= {m2_hh, 54'd0} + {26'd0, m2_hl, 27'd0} + {26'd0, m2_lh, 27'd0}
             + {52'd0, m2_ll};
      m3_es <= m2_es;
      m3_f  <= m2_f;

      m4_pn <= m3_p << lz;
      m4_e  <= {2'b00, m3_es} - 14'd1022 - 14'(lz);
      m4_f  <= m3_f;

      p     <= p_next;
    end
  end

endmodule

/* hw/rtl/float_tolerance_compare_top.sv */
// ----------------------------------------------------------------------------
// float_tolerance_compare_top: binary64 closeness test, real or complex
// A part passes when |a-b| <= abs_tolerance or |a-b| <= rel_tolerance *
// max(|a|,|b|); a complex pair needs both parts to pass. NaN handling and
// the nan_equal option are applied in the final stage.
//
//   channel  direction  handshake        payload
//   req      in         valid/ready      func, left/right real/imag (binary64)
//   rsp      out        valid/ready      is_close
//   cfg      in         cfg_we           cfg_index, cfg_data
//
// One transfer per cycle is accepted while not stalled; each passes the five
// arithmetic stages of the subtract and multiply units plus the result stage.
// Reset clears the tolerances to +0.0, nan_equal to 0 and all valid bits.
// The whole pipeline holds while a result waits; req.ready is low only then.
// ----------------------------------------------------------------------------
module float_tolerance_compare_top import ftc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ftc_req_if.sink     req,
  ftc_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] rel_tol, abs_tol;
  logic        nan_eq;
  logic        en;
  logic [5:1]  vld;
  ftc_side_t   side [5:1];
  ftc_side_t   side_in;
  logic [63:0] d_re, d_im, p_re, p_im;
  logic        ok_re, ok_im, close_next;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  always_comb begin
    side_in.func = req.func;
    side_in.lnan = f64_is_nan(req.left_real) || (req.func && f64_is_nan(req.left_imag));
    side_in.rnan = f64_is_nan(req.right_real) || (req.func && f64_is_nan(req.right_imag));
  end

  ftc_sub u_sub_re (.clk, .en, .a(req.left_real), .b(req.right_real), .d(d_re));
  ftc_sub u_sub_im (.clk, .en, .a(req.left_imag), .b(req.right_imag), .d(d_im));
  ftc_mul u_mul_re (.clk, .en, .rt(rel_tol), .a(req.left_real), .b(req.right_real),
                    .p(p_re));
  ftc_mul u_mul_im (.clk, .en, .rt(rel_tol), .a(req.left_imag), .b(req.right_imag),
                    .p(p_im));

  always_comb begin
    ok_re = f64_le(d_re, abs_tol) || f64_le(d_re, p_re);
    ok_im = f64_le(d_im, abs_tol) || f64_le(d_im, p_im);
    if (side[5].lnan || side[5].rnan) begin
      close_next = nan_eq && side[5].lnan && side[5].rnan;
    end else begin
      close_next = ok_re && (!side[5].func || ok_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_tol   <= 64'd0;
      abs_tol   <= 64'd0;
      nan_eq    <= 1'b0;
      vld       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_REL_TOL: rel_tol <= cfg_data;
          CFG_ABS_TOL: abs_tol <= cfg_data;
          CFG_NAN_EQ:  nan_eq  <= cfg_data[0];
          default: ;
        endcase
      end
      if (en) begin
        vld       <= {vld[4:1], req.valid};
        rsp.valid <= vld[5];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= side_in;
      for (int i = 2; i <= 5; i++) begin
        side[i] <= side[i-1];
      end
      rsp.is_close <= close_next;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valid bits moved during a stall");

  a_rsp_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(vld[5]))
    else $error("result appeared without an item in the last stage");

  a_nan_not_close: assert property (@(posedge clk) disable iff (rst)
    en && vld[5] && (side[5].lnan || side[5].rnan) && !nan_eq |=> !rsp.is_close)
    else $error("NaN operand reported as close");

endmodule

/* tb/sv/tb_float_tolerance_compare_top.sv */
// ----------------------------------------------------------------------------
// tb_float_tolerance_compare_top: self-checking bench for the tolerance compare
// Sends real and complex binary64 operand pairs over the request channel
// under several tolerance settings. Each accepted transfer is scored against
// a closeness predictor that uses the simulator's double arithmetic. Results
// are checked in order as they leave the response channel, with random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_float_tolerance_compare_top import ftc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_REAL = 1'b0;
  localparam logic FUNC_CPLX = 1'b1;
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] F64_PINF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] F64_MAXN = 64'h7FEF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        func;
    logic [63:0] lr;
    logic [63:0] li;
    logic [63:0] rr;
    logic [63:0] ri;
  } pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  ftc_req_if req_ch ();
  ftc_rsp_if rsp_ch ();

  float_tolerance_compare_top dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Tolerance settings as the block should currently see them.
  logic [63:0] rel_tol_q = '0;
  logic [63:0] abs_tol_q = '0;
  logic        nan_eq_q  = 1'b0;

  pair_t pending_pairs[$];
  logic  close_expected[$];
  pair_t cur_pair;
  int    errors = 0;
  int    results_seen = 0;

  function automatic logic part_within_tol(logic [63:0] a, logic [63:0] b);
    real ra, rb, d, ma, mb, mx, rt, at;
    ra = $bitstoreal(a);
    rb = $bitstoreal(b);
    d  = $bitstoreal($realtobits(ra - rb) & ~SIGN_BIT);
    ma = $bitstoreal(a & ~SIGN_BIT);
    mb = $bitstoreal(b & ~SIGN_BIT);
    mx = (ma > mb) ? ma : mb;
    rt = $bitstoreal(rel_tol_q);
    at = $bitstoreal(abs_tol_q);
    return (d <= at) || (d <= rt * mx);
  endfunction

  function automatic logic is_nan64(logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic predict_close(pair_t p);
    logic ln, rn;
    ln = is_nan64(p.lr) || (p.func == FUNC_CPLX && is_nan64(p.li));
    rn = is_nan64(p.rr) || (p.func == FUNC_CPLX && is_nan64(p.ri));
    if (ln || rn) begin
      return nan_eq_q && ln && rn;
    end else if (p.func == FUNC_CPLX) begin
      return part_within_tol(p.lr, p.rr) && part_within_tol(p.li, p.ri);
    end
    return part_within_tol(p.lr, p.rr);
  endfunction

  function automatic logic [63:0] rand_bits64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = {$urandom_range(0, 1) == 1, 63'd0};
      1: v = F64_PINF | (($urandom_range(0, 1) == 1) ? SIGN_BIT : 64'd0);
      2: v = F64_PINF | {12'd0, ($urandom_range(0, 1) == 1), 19'd0, $urandom}
             | 64'd1 | (($urandom_range(0, 1) == 1) ? SIGN_BIT : 64'd0);
      3: v = F64_MAXN | (($urandom_range(0, 1) == 1) ? SIGN_BIT : 64'd0);
      4: v = {$urandom_range(0, 1) == 1, 11'd0, 20'd0, $urandom};
      5, 6: v = rand_bits64();
      default: v = {$urandom_range(0, 1) == 1, 11'($urandom_range(980, 1070)),
                    20'($urandom), $urandom};
    endcase
    return v;
  endfunction

  // Second operand mostly near the first so that tolerances decide.
  function automatic logic [63:0] near_operand(logic [63:0] a);
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = a;
      1: v = a ^ SIGN_BIT;
      2: v = rand_operand();
      3: v = a + (64'($urandom_range(0, 1)) << $urandom_range(0, 50));
      default: v = a + 64'($urandom_range(0, 4000)) - 64'd2000;
    endcase
    return v;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.func = 1'($urandom_range(0, 1));
    p.lr = rand_operand();
    p.li = rand_operand();
    p.rr = near_operand(p.lr);
    p.ri = near_operand(p.li);
    return p;
  endfunction

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.func <= FUNC_REAL;
      req_ch.left_real <= '0;
      req_ch.left_imag <= '0;
      req_ch.right_real <= '0;
      req_ch.right_imag <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        close_expected.push_back(predict_close(cur_pair));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          cur_pair = pending_pairs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.func <= cur_pair.func;
          req_ch.left_real <= cur_pair.lr;
          req_ch.left_imag <= cur_pair.li;
          req_ch.right_real <= cur_pair.rr;
          req_ch.right_imag <= cur_pair.ri;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: receiver stalls on a changing pattern, plus one long hold-off.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (close_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result is_close=%0b", $time, rsp_ch.is_close);
        end else begin
          logic want;
          want = close_expected.pop_front();
          if (rsp_ch.is_close !== want) begin
            errors++;
            $display("%0t: is_close mismatch expected=%0b actual=%0b",
                     $time, want, rsp_ch.is_close);
          end
        end
      end
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_REL_TOL) rel_tol_q = val;
    else if (idx == CFG_ABS_TOL) abs_tol_q = val;
    else if (idx == CFG_NAN_EQ) nan_eq_q = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || req_ch.valid || close_expected.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_tols(logic [63:0] rt, logic [63:0] at, logic ne);
    write_reg(CFG_REL_TOL, rt);
    write_reg(CFG_ABS_TOL, at);
    write_reg(CFG_NAN_EQ, {63'd0, ne});
  endtask

  task automatic add(logic f, logic [63:0] a, logic [63:0] ai,
                     logic [63:0] b, logic [63:0] bi);
    pair_t p;
    p.func = f; p.lr = a; p.li = ai; p.rr = b; p.ri = bi;
    pending_pairs.push_back(p);
  endtask

  task automatic random_phase(int n);
    repeat (n) pending_pairs.push_back(rand_pair());
    drain();
  endtask

  initial begin
    logic [63:0] one, zero, qnan, snan;
    one = $realtobits(1.0);
    zero = 64'd0;
    qnan = F64_QNAN;
    snan = 64'h7FF0_0000_0000_0001;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_tols($realtobits(1.0e-9), $realtobits(1.0e-12), 1'b1);

    // Directed corner cases.
    add(FUNC_REAL, zero, zero, zero ^ SIGN_BIT, zero);
    add(FUNC_REAL, one, zero, one + 64'd1, zero);
    add(FUNC_REAL, one, zero, one + 64'd100000, zero);
    add(FUNC_REAL, F64_PINF, zero, F64_PINF, zero);
    add(FUNC_REAL, F64_PINF, zero, F64_PINF | SIGN_BIT, zero);
    add(FUNC_REAL, F64_MAXN, zero, F64_MAXN | SIGN_BIT, zero);
    add(FUNC_REAL, qnan, zero, qnan, zero);
    add(FUNC_REAL, snan | SIGN_BIT, zero, one, zero);
    add(FUNC_REAL, one, zero, qnan, zero);
    add(FUNC_REAL, one, qnan, one, 64'hFFFF_FFFF_FFFF_FFFF);
    add(FUNC_REAL, 64'd1, zero, 64'd2, zero);
    add(FUNC_CPLX, one, qnan, one, one);
    add(FUNC_CPLX, one, qnan, qnan, one);
    add(FUNC_CPLX, one, one, one, one + 64'd1);
    add(FUNC_CPLX, one, one, one, F64_PINF);
    add(FUNC_CPLX, F64_MAXN, F64_PINF, F64_MAXN, F64_PINF);
    add(FUNC_CPLX, 64'hFFFF_FFFF_FFFF_FFFF, zero, 64'hFFFF_FFFF_FFFF_FFFF, zero);
    random_phase(200);

    set_tols(64'd0, 64'd0, 1'b0);
    add(FUNC_REAL, qnan, zero, qnan, zero);
    add(FUNC_CPLX, one, qnan, qnan, one);
    random_phase(200);

    set_tols($realtobits(0.5), $realtobits(1.0e-300), 1'b1);
    random_phase(200);

    // Extreme tolerances: NaN, infinite, negative, largest finite.
    set_tols(64'hFFFF_FFFF_FFFF_FFFF, F64_PINF, 1'b0);
    random_phase(200);
    set_tols($realtobits(-1.0), $realtobits(-1.0e-3), 1'b1);
    random_phase(200);
    set_tols(F64_MAXN, 64'd1, 1'b0);
    random_phase(200);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
